// ===== rtl/brm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the Bruck round route-and-merge block.
package brm_pkg;

  localparam int RANK_W    = 12;
  localparam int CNT_W     = 13;
  localparam int OFF_W     = 24;
  localparam int ELEM_W    = 16;
  localparam int SID_W     = 3;
  localparam int ENT_W     = RANK_W + CNT_W;
  localparam int PROD_W    = CNT_W + ELEM_W;
  localparam int AMT_W     = PROD_W + 1;
  localparam int HDR_BYTES = 8;
  localparam int CNT_MAX   = (1 << CNT_W) - 1;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_MERGE    = 2'd1,
    OP_CLASSIFY = 2'd2,
    OP_CLEAR    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    K_HDR   = 2'd0,
    K_SEG   = 2'd1,
    K_DONE  = 2'd2,
    K_CLASS = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_MY_RANK      = 3'd0,
    REG_NUM_RANKS    = 3'd1,
    REG_ROUND_FACTOR = 3'd2,
    REG_RADIX        = 3'd3,
    REG_ACTIVE       = 3'd4,
    REG_ELEM_BYTES   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [RANK_W-1:0] my_rank;
    logic [CNT_W-1:0]  num_ranks;
    logic [CNT_W-1:0]  round_factor;
    logic [3:0]        radix;
    logic [SID_W-1:0]  active_streams;
    logic [ELEM_W-1:0] elem_bytes;
  } cfg_t;

  typedef struct packed {
    kind_t             kind;
    logic [RANK_W-1:0] out_rank;
    logic [CNT_W-1:0]  out_count;
    logic [SID_W-1:0]  src_stream;
    logic [OFF_W-1:0]  src_offset;
    logic [OFF_W-1:0]  merged_offset;
    logic [2:0]        send_port;
    logic              last;
  } res_t;

  typedef enum logic [4:0] {
    A_NONE,
    A_ACCEPT,
    A_LOAD_WR,
    A_LOAD_ERR,
    A_CLEAR,
    A_DIG_START,
    A_MUL,
    A_CLS_PUSH,
    A_SKIP_LATCH,
    A_SKIP_ADV,
    A_SCAN_INIT,
    A_SCAN_DATA,
    A_PUSH_DONE,
    A_GATHER_INIT,
    A_GATHER,
    A_PUSH_HDR,
    A_NEXT_S,
    A_PUSH_SEG,
    A_EMIT
  } act_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_LOAD,
    S_CLEAR,
    S_CLS_DIG,
    S_CLS_WAIT,
    S_CLS_PUSH,
    S_SKIP_CHK,
    S_SKIP_DATA,
    S_SKIP_WAIT,
    S_SKIP_ADV,
    S_SCAN_RD,
    S_SCAN_DATA,
    S_SCAN_END,
    S_GATHER,
    S_HDR,
    S_SEG_CHK,
    S_SEG_PUSH,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_PHASE
  } dig_state_t;

  typedef struct packed {
    act_t act;
  } cmd_t;

  typedef struct packed {
    logic    accepted;
    opcode_t op;
    logic    load_bad;
    logic    dig_done;
    logic    dig_zero;
    logic    head0_avail;
    logic    scan_last;
    logic    found;
    logic    hit_cur;
    logic    emit_done;
  } sts_t;

  // Add to a 24-bit offset; top bit flags a wrap past the offset range.
  function automatic logic [OFF_W:0] off_add(logic [OFF_W-1:0] base, logic [AMT_W-1:0] amt);
    logic [AMT_W:0] s;
    s = (AMT_W+1)'(base) + (AMT_W+1)'(amt);
    return {|s[AMT_W:OFF_W], s[OFF_W-1:0]};
  endfunction

endpackage

// ===== rtl/brm_if.sv =====
`timescale 1ns / 1ps
// Request and response channel interfaces.
interface brm_req_if;
  import brm_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [SID_W-1:0]  stream_id;
  logic [RANK_W-1:0] dest_rank;
  logic [CNT_W-1:0]  msg_count;
  modport source(output valid, opcode, stream_id, dest_rank, msg_count, input ready);
  modport sink(input valid, opcode, stream_id, dest_rank, msg_count, output ready);
endinterface

interface brm_rsp_if;
  import brm_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [RANK_W-1:0] out_rank;
  logic [CNT_W-1:0]  out_count;
  logic [SID_W-1:0]  src_stream;
  logic [OFF_W-1:0]  src_offset;
  logic [OFF_W-1:0]  merged_offset;
  logic [2:0]        send_port;
  logic              error;
  logic              last;
  modport source(output valid, kind, out_rank, out_count, src_stream, src_offset,
                 merged_offset, send_port, error, last, input ready);
  modport sink(input valid, kind, out_rank, out_count, src_stream, src_offset,
               merged_offset, send_port, error, last, output ready);
endinterface

// ===== rtl/bruck_round_route_and_merge_top.sv =====
`timescale 1ns / 1ps
// Top level: APB register file, controller and datapath.
// Classify waits on the digit unit, which runs four 13-step restoring
// divisions in sequence.
// A merge step runs the digit unit for each own-buffer header it checks, then scans
// the receive streams, gathers the contributing ones and emits the result beats.
// Synchronous reset clears pointers, offsets and registers; the header store
// keeps no reset and needs no clearing pass.
module bruck_round_route_and_merge_top import brm_pkg::*; #(
  parameter int MAX_STREAMS  = 8,
  parameter int STREAM_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  brm_req_if.sink     req,
  brm_rsp_if.source   rsp
);
  cfg_t     cfg;
  cmd_t     cmd;
  sts_t     st;
  reg_idx_t ridx;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.my_rank        <= '0;
      cfg.num_ranks      <= CNT_W'(1);
      cfg.round_factor   <= CNT_W'(1);
      cfg.radix          <= 4'd2;
      cfg.active_streams <= '0;
      cfg.elem_bytes     <= ELEM_W'(4);
    end else if (psel && penable && pwrite && pready) begin
      unique case (ridx)
        REG_MY_RANK:      cfg.my_rank        <= pwdata[RANK_W-1:0];
        REG_NUM_RANKS:    cfg.num_ranks      <= pwdata[CNT_W-1:0];
        REG_ROUND_FACTOR: cfg.round_factor   <= pwdata[CNT_W-1:0];
        REG_RADIX:        cfg.radix          <= pwdata[3:0];
        REG_ACTIVE:       cfg.active_streams <= pwdata[SID_W-1:0];
        REG_ELEM_BYTES:   cfg.elem_bytes     <= pwdata[ELEM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_MY_RANK:      prdata = 32'(cfg.my_rank);
      REG_NUM_RANKS:    prdata = 32'(cfg.num_ranks);
      REG_ROUND_FACTOR: prdata = 32'(cfg.round_factor);
      REG_RADIX:        prdata = 32'(cfg.radix);
      REG_ACTIVE:       prdata = 32'(cfg.active_streams);
      REG_ELEM_BYTES:   prdata = 32'(cfg.elem_bytes);
      default:          prdata = '0;
    endcase
  end

  brm_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  brm_dp #(
    .MAX_STREAMS  (MAX_STREAMS),
    .STREAM_DEPTH (STREAM_DEPTH)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .cmd (cmd),
    .st  (st),
    .req (req),
    .rsp (rsp)
  );
endmodule

// ===== rtl/brm_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module brm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/brm_digit.sv =====
`timescale 1ns / 1ps
// Digit unit: ((rank - my_rank) mod n / factor) mod radix by iterative restoring division.
module brm_digit import brm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RANK_W-1:0] rank,
  input  cfg_t              cfg,
  output logic              done,
  output logic [2:0]        digit
);
  dig_state_t       dstate;
  logic [1:0]       phase;
  logic [3:0]       step;
  logic [CNT_W:0]   rem;
  logic [CNT_W-1:0] quo;
  logic [CNT_W-1:0] dvs;
  logic [CNT_W-1:0] amod;

  logic [CNT_W-1:0] n_eff, f_eff, r_eff;
  logic [CNT_W:0]   rem_sh;
  logic             ge;
  logic [CNT_W+1:0] rel_sum;
  logic [CNT_W-1:0] rel;

  always_comb begin
    n_eff = (cfg.num_ranks == '0) ? CNT_W'(1) : cfg.num_ranks;
    f_eff = (cfg.round_factor == '0) ? CNT_W'(1) : cfg.round_factor;
    if (cfg.radix < 4'd2) begin
      r_eff = CNT_W'(2);
    end else if (cfg.radix > 4'd8) begin
      r_eff = CNT_W'(8);
    end else begin
      r_eff = CNT_W'(cfg.radix);
    end
    rem_sh  = {rem[CNT_W-1:0], quo[CNT_W-1]};
    ge      = rem_sh >= {1'b0, dvs};
    // both residues are below n, so one subtract brings the sum back in range
    rel_sum = (CNT_W+2)'(amod) + (CNT_W+2)'(n_eff) - (CNT_W+2)'(rem[CNT_W-1:0]);
    rel     = (rel_sum >= (CNT_W+2)'(n_eff)) ? CNT_W'(rel_sum - (CNT_W+2)'(n_eff))
                                              : CNT_W'(rel_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= D_IDLE;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (dstate)
        D_IDLE: begin
          if (start) begin
            quo    <= CNT_W'(rank);
            dvs    <= n_eff;
            rem    <= '0;
            phase  <= 2'd0;
            step   <= '0;
            dstate <= D_RUN;
          end
        end
        D_RUN: begin
          rem  <= ge ? (rem_sh - {1'b0, dvs}) : rem_sh;
          quo  <= {quo[CNT_W-2:0], ge};
          step <= step + 4'd1;
          if (step == 4'(CNT_W - 1)) begin
            dstate <= D_PHASE;
          end
        end
        D_PHASE: begin
          step <= '0;
          unique case (phase)
            2'd0: begin
              amod   <= rem[CNT_W-1:0];
              quo    <= CNT_W'(cfg.my_rank);
              rem    <= '0;
              phase  <= 2'd1;
              dstate <= D_RUN;
            end
            2'd1: begin
              quo    <= rel;
              dvs    <= f_eff;
              rem    <= '0;
              phase  <= 2'd2;
              dstate <= D_RUN;
            end
            2'd2: begin
              dvs    <= r_eff;
              rem    <= '0;
              phase  <= 2'd3;
              dstate <= D_RUN;
            end
            default: begin
              digit  <= rem[2:0];
              done   <= 1'b1;
              dstate <= D_IDLE;
            end
          endcase
        end
        default: dstate <= D_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/brm_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences load, clear, classify and merge steps over the datapath.
module brm_ctrl import brm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  sts_t st,
  output cmd_t cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (st.accepted) state_next = S_DECODE;
      S_DECODE: begin
        unique case (st.op)
          OP_LOAD:     state_next = S_LOAD;
          OP_MERGE:    state_next = S_SKIP_CHK;
          OP_CLASSIFY: state_next = S_CLS_DIG;
          default:     state_next = S_CLEAR;
        endcase
      end
      S_LOAD:      state_next = st.load_bad ? S_EMIT : S_IDLE;
      S_CLEAR:     state_next = S_IDLE;
      S_CLS_DIG:   state_next = S_CLS_WAIT;
      S_CLS_WAIT:  if (st.dig_done) state_next = S_CLS_PUSH;
      S_CLS_PUSH:  state_next = S_EMIT;
      S_SKIP_CHK:  state_next = st.head0_avail ? S_SKIP_DATA : S_SCAN_RD;
      S_SKIP_DATA: state_next = S_SKIP_WAIT;
      S_SKIP_WAIT: begin
        if (st.dig_done) state_next = st.dig_zero ? S_SCAN_RD : S_SKIP_ADV;
      end
      S_SKIP_ADV:  state_next = S_SKIP_CHK;
      S_SCAN_RD:   state_next = S_SCAN_DATA;
      S_SCAN_DATA: state_next = st.scan_last ? S_SCAN_END : S_SCAN_RD;
      S_SCAN_END:  state_next = st.found ? S_GATHER : S_EMIT;
      S_GATHER:    if (st.scan_last) state_next = S_HDR;
      S_HDR:       state_next = S_SEG_CHK;
      S_SEG_CHK: begin
        if (st.hit_cur) begin
          state_next = S_SEG_PUSH;
        end else if (st.scan_last) begin
          state_next = S_EMIT;
        end
      end
      S_SEG_PUSH:  state_next = st.scan_last ? S_EMIT : S_SEG_CHK;
      S_EMIT:      if (st.emit_done) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.act = A_NONE;
    unique case (state)
      S_IDLE:      cmd.act = A_ACCEPT;
      S_LOAD:      cmd.act = st.load_bad ? A_LOAD_ERR : A_LOAD_WR;
      S_CLEAR:     cmd.act = A_CLEAR;
      S_CLS_DIG:   cmd.act = A_DIG_START;
      S_CLS_WAIT:  cmd.act = st.dig_done ? A_MUL : A_NONE;
      S_CLS_PUSH:  cmd.act = A_CLS_PUSH;
      S_SKIP_CHK:  cmd.act = st.head0_avail ? A_NONE : A_SCAN_INIT;
      S_SKIP_DATA: cmd.act = A_SKIP_LATCH;
      S_SKIP_WAIT: begin
        if (st.dig_done) cmd.act = st.dig_zero ? A_SCAN_INIT : A_MUL;
      end
      S_SKIP_ADV:  cmd.act = A_SKIP_ADV;
      S_SCAN_DATA: cmd.act = A_SCAN_DATA;
      S_SCAN_END:  cmd.act = st.found ? A_GATHER_INIT : A_PUSH_DONE;
      S_GATHER:    cmd.act = A_GATHER;
      S_HDR:       cmd.act = A_PUSH_HDR;
      S_SEG_CHK: begin
        if (st.hit_cur) begin
          cmd.act = A_MUL;
        end else if (!st.scan_last) begin
          cmd.act = A_NEXT_S;
        end
      end
      S_SEG_PUSH:  cmd.act = A_PUSH_SEG;
      S_EMIT:      cmd.act = A_EMIT;
      default:     cmd.act = A_NONE;
    endcase
  end
endmodule

// ===== rtl/brm_dp.sv =====
`timescale 1ns / 1ps
// Datapath: header store, stream pointers, offsets, merge scan and result buffer.
module brm_dp import brm_pkg::*; #(
  parameter int MAX_STREAMS  = 8,
  parameter int STREAM_DEPTH = 64
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  cmd_t cmd,
  output sts_t st,
  brm_req_if.sink   req,
  brm_rsp_if.source rsp
);
  localparam int SW   = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
  localparam int IW   = $clog2(STREAM_DEPTH);
  localparam int HW   = $clog2(STREAM_DEPTH + 1);
  localparam int AW   = SW + IW;
  localparam int NBUF = MAX_STREAMS + 1;
  localparam int BW   = $clog2(NBUF + 1);
  localparam int TW   = CNT_W + SW;

  opcode_t           op_r;
  logic [SID_W-1:0]  sid_r;
  logic [RANK_W-1:0] dest_r;
  logic [CNT_W-1:0]  cnt_r;

  logic [HW-1:0]    head [MAX_STREAMS];
  logic [HW-1:0]    tail [MAX_STREAMS];
  logic [OFF_W-1:0] sbo  [MAX_STREAMS];
  logic [OFF_W-1:0] port_fill [8];
  logic [OFF_W-1:0] merge_off;

  logic [SW-1:0]      s;
  logic [ENT_W-1:0]   ent [MAX_STREAMS];
  logic [MAX_STREAMS-1:0] vld, hit;
  logic [RANK_W-1:0]  min_rank;
  logic               found;
  logic [TW-1:0]      total;
  logic [SW-1:0]      last_s;
  logic [PROD_W-1:0]  prod;
  logic               step_err;

  res_t           rbuf [NBUF];
  logic [BW-1:0]  wr, rd;
  res_t           out_r;
  logic           out_v;
  logic           out_err;

  logic [ENT_W-1:0] rdata;
  logic             dig_start, dig_done;
  logic [2:0]       digit;
  logic [RANK_W-1:0] dig_rank;

  logic [SW-1:0]     sid_idx, nrecv;
  logic              load_bad, scan_last, emit_go;
  logic [RANK_W-1:0] rd_rank, ent_rank;
  logic [CNT_W-1:0]  ent_cnt, mul_cnt, tot_sat;
  logic              sat_err;
  logic [AMT_W-1:0]  pkt;
  logic [OFF_W:0]    cls_add, hdr_add, soff_add, moff_add, sbo_add;
  logic              push_en;
  res_t              push_res;

  brm_ram #(.WIDTH(ENT_W), .DEPTH(2 ** AW)) u_store (
    .clk   (clk),
    .we    (cmd.act == A_LOAD_WR),
    .waddr ({sid_idx, tail[sid_idx][IW-1:0]}),
    .wdata ({dest_r, cnt_r}),
    .raddr ({s, head[s][IW-1:0]}),
    .rdata (rdata)
  );

  brm_digit u_digit (
    .clk   (clk),
    .rst   (rst),
    .start (dig_start),
    .rank  (dig_rank),
    .cfg   (cfg),
    .done  (dig_done),
    .digit (digit)
  );

  always_comb begin
    sid_idx   = SW'(sid_r);
    load_bad  = (int'(sid_r) >= MAX_STREAMS) || (tail[sid_idx] >= HW'(STREAM_DEPTH));
    if (int'(cfg.active_streams) > MAX_STREAMS - 1) begin
      nrecv = SW'(MAX_STREAMS - 1);
    end else begin
      nrecv = SW'(cfg.active_streams);
    end
    scan_last = (s == nrecv);
    rd_rank   = rdata[ENT_W-1:CNT_W];
    ent_rank  = ent[s][ENT_W-1:CNT_W];
    ent_cnt   = ent[s][CNT_W-1:0];
    mul_cnt   = (op_r == OP_CLASSIFY) ? cnt_r : ent_cnt;
    dig_start = (cmd.act == A_DIG_START) || (cmd.act == A_SKIP_LATCH);
    dig_rank  = (cmd.act == A_SKIP_LATCH) ? rd_rank : dest_r;
    sat_err   = total > TW'(CNT_MAX);
    tot_sat   = sat_err ? CNT_W'(CNT_MAX) : CNT_W'(total);
    pkt       = AMT_W'(prod) + AMT_W'(HDR_BYTES);
    cls_add   = off_add(port_fill[digit], pkt);
    hdr_add   = off_add(merge_off, AMT_W'(HDR_BYTES));
    soff_add  = off_add(sbo[s], AMT_W'(HDR_BYTES));
    moff_add  = off_add(merge_off, AMT_W'(prod));
    sbo_add   = off_add(sbo[s], pkt);
    emit_go   = (cmd.act == A_EMIT) && (rd != wr) && (!out_v || rsp.ready);

    push_en  = 1'b0;
    push_res = '0;
    unique case (cmd.act)
      A_LOAD_ERR: begin
        push_en       = 1'b1;
        push_res.kind = K_DONE;
        push_res.last = 1'b1;
      end
      A_CLS_PUSH: begin
        push_en            = 1'b1;
        push_res.kind      = K_CLASS;
        push_res.out_rank  = dest_r;
        push_res.out_count = cnt_r;
        push_res.src_offset = (digit != 3'd0) ? port_fill[digit] : '0;
        push_res.send_port = digit;
        push_res.last      = 1'b1;
      end
      A_PUSH_DONE: begin
        push_en               = 1'b1;
        push_res.kind         = K_DONE;
        push_res.merged_offset = merge_off;
        push_res.last         = 1'b1;
      end
      A_PUSH_HDR: begin
        push_en               = 1'b1;
        push_res.kind         = K_HDR;
        push_res.out_rank     = min_rank;
        push_res.out_count    = tot_sat;
        push_res.merged_offset = merge_off;
      end
      A_PUSH_SEG: begin
        push_en               = 1'b1;
        push_res.kind         = K_SEG;
        push_res.out_rank     = min_rank;
        push_res.out_count    = ent_cnt;
        push_res.src_stream   = SID_W'(s);
        push_res.src_offset   = soff_add[OFF_W-1:0];
        push_res.merged_offset = merge_off;
        push_res.last         = (s == last_s);
      end
      default: push_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_STREAMS; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        sbo[i]  <= '0;
      end
      for (int i = 0; i < 8; i++) begin
        port_fill[i] <= '0;
      end
      merge_off <= '0;
      wr        <= '0;
      rd        <= '0;
      out_v     <= 1'b0;
      s         <= '0;
      found     <= 1'b0;
      step_err  <= 1'b0;
    end else begin
      // output register: take the next beat when it is free or being drained
      if (emit_go) begin
        out_r   <= rbuf[rd];
        out_err <= step_err;
        out_v   <= 1'b1;
        rd      <= rd + BW'(1);
      end else if (rsp.ready) begin
        out_v <= 1'b0;
      end

      if (push_en) begin
        rbuf[wr] <= push_res;
        wr       <= wr + BW'(1);
      end

      unique case (cmd.act)
        A_ACCEPT: begin
          if (req.valid) begin
            op_r     <= opcode_t'(req.opcode);
            sid_r    <= req.stream_id;
            dest_r   <= req.dest_rank;
            cnt_r    <= req.msg_count;
            s        <= '0;
            wr       <= '0;
            rd       <= '0;
            step_err <= 1'b0;
          end
        end
        A_LOAD_WR:  tail[sid_idx] <= tail[sid_idx] + HW'(1);
        A_LOAD_ERR: step_err <= 1'b1;
        A_CLEAR: begin
          for (int i = 0; i < MAX_STREAMS; i++) begin
            head[i] <= '0;
            tail[i] <= '0;
            sbo[i]  <= '0;
          end
          for (int i = 0; i < 8; i++) begin
            port_fill[i] <= '0;
          end
          merge_off <= '0;
        end
        A_MUL: prod <= PROD_W'(mul_cnt) * PROD_W'(cfg.elem_bytes);
        A_CLS_PUSH: begin
          if (digit != 3'd0) begin
            port_fill[digit] <= cls_add[OFF_W-1:0];
            step_err         <= cls_add[OFF_W];
          end
        end
        A_SKIP_LATCH: ent[s] <= rdata;
        A_SKIP_ADV: begin
          sbo[s]  <= sbo_add[OFF_W-1:0];
          head[s] <= head[s] + HW'(1);
          if (sbo_add[OFF_W]) step_err <= 1'b1;
        end
        A_SCAN_INIT: begin
          s     <= '0;
          found <= 1'b0;
        end
        A_SCAN_DATA: begin
          ent[s] <= rdata;
          vld[s] <= head[s] < tail[s];
          if ((head[s] < tail[s]) && (!found || rd_rank < min_rank)) begin
            min_rank <= rd_rank;
            found    <= 1'b1;
          end
          if (!scan_last) s <= s + SW'(1);
        end
        A_GATHER_INIT: begin
          s     <= '0;
          total <= '0;
          hit   <= '0;
        end
        A_GATHER: begin
          if (vld[s] && ent_rank == min_rank) begin
            hit[s] <= 1'b1;
            total  <= total + TW'(ent_cnt);
            last_s <= s;
          end
          if (!scan_last) s <= s + SW'(1);
        end
        A_PUSH_HDR: begin
          merge_off <= hdr_add[OFF_W-1:0];
          if (sat_err || hdr_add[OFF_W]) step_err <= 1'b1;
          s <= '0;
        end
        A_NEXT_S: s <= s + SW'(1);
        A_PUSH_SEG: begin
          merge_off <= moff_add[OFF_W-1:0];
          sbo[s]    <= sbo_add[OFF_W-1:0];
          head[s]   <= head[s] + HW'(1);
          if (soff_add[OFF_W] || moff_add[OFF_W] || sbo_add[OFF_W]) step_err <= 1'b1;
          if (!scan_last) s <= s + SW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  assign req.ready = (cmd.act == A_ACCEPT);

  always_comb begin
    st.accepted    = req.valid && req.ready;
    st.op          = op_r;
    st.load_bad    = load_bad;
    st.dig_done    = dig_done;
    st.dig_zero    = (digit == 3'd0);
    st.head0_avail = head[0] < tail[0];
    st.scan_last   = scan_last;
    st.found       = found;
    st.hit_cur     = hit[s];
    st.emit_done   = (rd == wr);
  end

  assign rsp.valid         = out_v;
  assign rsp.kind          = out_r.kind;
  assign rsp.out_rank      = out_r.out_rank;
  assign rsp.out_count     = out_r.out_count;
  assign rsp.src_stream    = out_r.src_stream;
  assign rsp.src_offset    = out_r.src_offset;
  assign rsp.merged_offset = out_r.merged_offset;
  assign rsp.send_port     = out_r.send_port;
  assign rsp.error         = out_err;
  assign rsp.last          = out_r.last;

  a_buf_bound: assert property (@(posedge clk) disable iff (rst) wr <= BW'(NBUF))
    else $error("result buffer overrun");
  a_rd_le_wr: assert property (@(posedge clk) disable iff (rst) rd <= wr)
    else $error("result read pointer passed write pointer");
  a_head_tail: assert property (@(posedge clk) disable iff (rst) head[0] <= tail[0])
    else $error("own stream head passed its tail");
  a_seg_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.act == A_PUSH_SEG |-> hit[s])
    else $error("segment pushed for a stream that did not match");
endmodule

// ===== sim/brm_route_merge_checker.sv =====
`timescale 1ns / 1ps
// Watches the request, response and register port, predicts results and compares them.
module brm_route_merge_checker import brm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  brm_req_if          req,
  brm_rsp_if          rsp,
  output int          errors,
  output int          pending
);

  localparam int NSTREAM = 8;
  localparam int DEPTH   = 64;

  typedef struct {
    kind_t             kind;
    logic [RANK_W-1:0] rank;
    logic [CNT_W-1:0]  count;
    logic [SID_W-1:0]  strm;
    logic [OFF_W-1:0]  soff;
    logic [OFF_W-1:0]  moff;
    logic [2:0]        port;
    logic              err;
    logic              last;
  } beat_t;

  typedef struct {
    logic [RANK_W-1:0] rank;
    logic [CNT_W-1:0]  count;
  } hdr_t;

  hdr_t              hdr_mem [NSTREAM][DEPTH];
  int                head [NSTREAM];
  int                tail [NSTREAM];
  logic [OFF_W-1:0]  strm_off [NSTREAM];
  logic [OFF_W-1:0]  port_off [8];
  logic [OFF_W-1:0]  merge_off;

  logic [RANK_W-1:0] my_rank;
  logic [CNT_W-1:0]  num_ranks;
  logic [CNT_W-1:0]  round_factor;
  logic [3:0]        radix;
  logic [SID_W-1:0]  active;
  logic [ELEM_W-1:0] elem_bytes;

  beat_t expect_q[$];

  function automatic int digit_of(logic [RANK_W-1:0] dest);
    int n, f, r, rel;
    n = (num_ranks == 0) ? 1 : int'(num_ranks);
    f = (round_factor == 0) ? 1 : int'(round_factor);
    r = (radix < 2) ? 2 : ((radix > 8) ? 8 : int'(radix));
    rel = ((int'(dest) % n) + n - (int'(my_rank) % n)) % n;
    return (rel / f) % r;
  endfunction

  // Advance an offset with wrap; report a wrap past the range.
  function automatic bit bump(inout logic [OFF_W-1:0] off, input longint amt);
    longint s;
    s = longint'(off) + amt;
    off = s[OFF_W-1:0];
    return s > 64'hFFFFFF;
  endfunction

  function automatic beat_t mk(kind_t k, int rank, int cnt, int strm, logic [OFF_W-1:0] soff,
                               logic [OFF_W-1:0] moff, int port, bit err, bit last);
    beat_t b;
    b.kind = k; b.rank = rank; b.count = cnt; b.strm = strm; b.soff = soff;
    b.moff = moff; b.port = port; b.err = err; b.last = last;
    return b;
  endfunction

  function automatic longint pkt_bytes(logic [CNT_W-1:0] cnt);
    return 8 + longint'(cnt) * longint'(elem_bytes);
  endfunction

  task automatic clear_ptrs();
    for (int s = 0; s < NSTREAM; s++) begin
      head[s] = 0; tail[s] = 0; strm_off[s] = '0; port_off[s] = '0;
    end
    merge_off = '0;
  endtask

  task automatic predict_merge();
    beat_t outq[$];
    bit err, found, hit [NSTREAM];
    int nrecv, last_s, total, min_rank;
    logic [OFF_W-1:0] soff, moff;
    err = 0; found = 0; total = 0; min_rank = 0; last_s = 0;
    nrecv = active;
    // drop own-buffer headers that were sent away
    while (head[0] < tail[0] && digit_of(hdr_mem[0][head[0]].rank) != 0) begin
      if (bump(strm_off[0], pkt_bytes(hdr_mem[0][head[0]].count))) err = 1;
      head[0]++;
    end
    for (int s = 0; s <= nrecv; s++)
      if (head[s] < tail[s] && (!found || hdr_mem[s][head[s]].rank < min_rank)) begin
        min_rank = hdr_mem[s][head[s]].rank;
        found = 1;
      end
    if (!found) begin
      expect_q.push_back(mk(K_DONE, 0, 0, 0, 0, merge_off, 0, err, 1));
      return;
    end
    for (int s = 0; s < NSTREAM; s++) begin
      hit[s] = (s <= nrecv) && head[s] < tail[s] && hdr_mem[s][head[s]].rank == min_rank;
      if (hit[s]) begin
        total += hdr_mem[s][head[s]].count;
        last_s = s;
      end
    end
    if (total > CNT_MAX) begin
      total = CNT_MAX; err = 1;
    end
    outq.push_back(mk(K_HDR, min_rank, total, 0, 0, merge_off, 0, 0, 0));
    if (bump(merge_off, 8)) err = 1;
    for (int s = 0; s <= nrecv; s++) begin
      if (!hit[s]) continue;
      soff = strm_off[s];
      if (bump(soff, 8)) err = 1;
      moff = merge_off;
      if (bump(merge_off, longint'(hdr_mem[s][head[s]].count) * longint'(elem_bytes))) err = 1;
      if (bump(strm_off[s], pkt_bytes(hdr_mem[s][head[s]].count))) err = 1;
      outq.push_back(mk(K_SEG, min_rank, hdr_mem[s][head[s]].count, s, soff, moff, 0, 0,
                        s == last_s));
      head[s]++;
    end
    foreach (outq[i]) begin
      outq[i].err = err;
      expect_q.push_back(outq[i]);
    end
  endtask

  task automatic predict(opcode_t op, int sid, logic [RANK_W-1:0] dest, logic [CNT_W-1:0] cnt);
    int d;
    bit err;
    logic [OFF_W-1:0] off;
    case (op)
      OP_LOAD: begin
        if (tail[sid] >= DEPTH) begin
          expect_q.push_back(mk(K_DONE, 0, 0, 0, 0, 0, 0, 1, 1));
        end else begin
          hdr_mem[sid][tail[sid]].rank = dest;
          hdr_mem[sid][tail[sid]].count = cnt;
          tail[sid]++;
        end
      end
      OP_CLEAR: clear_ptrs();
      OP_CLASSIFY: begin
        d = digit_of(dest);
        off = '0;
        err = 0;
        if (d != 0) begin
          off = port_off[d];
          err = bump(port_off[d], pkt_bytes(cnt));
        end
        expect_q.push_back(mk(K_CLASS, dest, cnt, 0, off, 0, d, err, 1));
      end
      default: predict_merge();
    endcase
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    beat_t e;
    if (rst) begin
      clear_ptrs();
      expect_q.delete();
      errors <= 0;
      my_rank <= 0; num_ranks <= 1; round_factor <= 1; radix <= 2;
      active <= 0; elem_bytes <= 4;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expect_q.size() == 0) begin
          $error("unexpected response beat, kind %0d", rsp.kind);
          errors++;
        end else begin
          e = expect_q.pop_front();
          check_field("kind", e.kind, rsp.kind);
          check_field("out_rank", e.rank, rsp.out_rank);
          check_field("out_count", e.count, rsp.out_count);
          check_field("src_stream", e.strm, rsp.src_stream);
          check_field("src_offset", e.soff, rsp.src_offset);
          check_field("merged_offset", e.moff, rsp.merged_offset);
          check_field("send_port", e.port, rsp.send_port);
          check_field("error", e.err, rsp.error);
          check_field("last", e.last, rsp.last);
        end
      end
      if (req.valid && req.ready)
        predict(opcode_t'(req.opcode), req.stream_id, req.dest_rank, req.msg_count);
      if (psel && penable && pwrite) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_MY_RANK:      my_rank <= pwdata[RANK_W-1:0];
          REG_NUM_RANKS:    num_ranks <= pwdata[CNT_W-1:0];
          REG_ROUND_FACTOR: round_factor <= pwdata[CNT_W-1:0];
          REG_RADIX:        radix <= pwdata[3:0];
          REG_ACTIVE:       active <= pwdata[SID_W-1:0];
          REG_ELEM_BYTES:   elem_bytes <= pwdata[ELEM_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= expect_q.size();
  end

endmodule

// ===== sim/tb_bruck_round_route_and_merge_top.sv =====
`timescale 1ns / 1ps
// Testbench top: clock, reset, register setup, request stimulus and verdict.
module tb_bruck_round_route_and_merge_top;
  import brm_pkg::*;

  localparam int WATCHDOG = 20000;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          errors, pending;
  int          stall_cnt;
  int          rsp_beats;
  bit          gaps_on;
  bit          pressed;
  int          cur_ranks;
  int          cur_active;

  brm_req_if req ();
  brm_rsp_if rsp ();

  bruck_round_route_and_merge_top u_top (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req(req), .rsp(rsp)
  );

  brm_route_merge_checker u_chk (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .req(req), .rsp(rsp),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Stop when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) || psel) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= WATCHDOG) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // Response side: random stalls, one long hold-off to back the block up.
  initial begin
    int wait_n;
    rsp.ready <= 1'b0;
    rsp_beats = 0;
    pressed = 0;
    @(negedge rst);
    forever begin
      wait_n = gaps_on ? $urandom_range(0, 16) : 0;
      if (!pressed && rsp_beats >= 60) begin
        wait_n = 600;
        pressed = 1;
      end
      if (wait_n > 0) begin
        rsp.ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      rsp_beats++;
    end
  end

  task automatic send(opcode_t op, int sid, int dest, int cnt);
    int gap;
    gap = gaps_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.opcode    <= op;
    req.stream_id <= sid;
    req.dest_rank <= dest;
    req.msg_count <= cnt;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic reg_write(reg_idx_t idx, int value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(idx * 4); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Let everything drain, then let trailing work settle.
  task automatic drain();
    req.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic setup(int me, int nr, int rf, int rad, int act, int eb);
    reg_write(REG_MY_RANK, me);
    reg_write(REG_NUM_RANKS, nr);
    reg_write(REG_ROUND_FACTOR, rf);
    reg_write(REG_RADIX, rad);
    reg_write(REG_ACTIVE, act);
    reg_write(REG_ELEM_BYTES, eb);
    cur_ranks = (nr & 13'h1FFF) == 0 ? 1 : ((nr & 13'h1FFF) > 4096 ? 4096 : nr & 13'h1FFF);
    cur_active = act & 7;
  endtask

  function automatic int pick_count();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, CNT_MAX) : $urandom_range(0, 20);
  endfunction

  // Load ascending headers into one stream.
  task automatic fill_stream(int sid, int n);
    int r;
    r = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      send(OP_LOAD, sid, (r >= cur_ranks) ? cur_ranks - 1 : r, pick_count());
      r += $urandom_range(0, 3);
      if ($urandom_range(0, 7) == 0)
        send(OP_CLASSIFY, $urandom_range(0, 7), $urandom_range(0, 4095), pick_count());
    end
  endtask

  task automatic run_round(int own_n, int recv_n, int burst_sid);
    int steps;
    gaps_on = $urandom_range(0, 3) != 0;
    send(OP_CLEAR, $urandom_range(0, 7), $urandom_range(0, 4095), $urandom_range(0, CNT_MAX));
    fill_stream(0, own_n);
    for (int s = 1; s <= cur_active; s++) fill_stream(s, recv_n);
    steps = own_n + cur_active * recv_n + 2;
    if (burst_sid >= 0) begin
      // overrun one store to hit the full case
      for (int i = 0; i < 66; i++)
        send(OP_LOAD, burst_sid, $urandom_range(0, 4095), $urandom_range(0, CNT_MAX));
      steps += 66;
    end
    for (int i = 0; i < steps; i++) begin
      send(OP_MERGE, $urandom_range(0, 7), $urandom_range(0, 4095), $urandom_range(0, CNT_MAX));
      if ($urandom_range(0, 3) == 0) begin
        gaps_on = $urandom_range(0, 3) != 0;
        send(OP_CLASSIFY, 0, $urandom_range(0, cur_ranks - 1), pick_count());
      end
    end
    drain();
  endtask

  initial begin
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    req.valid <= 1'b0; req.opcode <= OP_LOAD; req.stream_id <= '0;
    req.dest_rank <= '0; req.msg_count <= '0;
    gaps_on = 1;
    rst <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, empty merge, saturation, every opcode
    setup(5, 16, 1, 2, 7, 4);
    send(OP_MERGE, 0, 0, 0);
    send(OP_CLASSIFY, 0, 0, 0);
    send(OP_CLASSIFY, 0, 4095, CNT_MAX);
    send(OP_CLASSIFY, 7, 6, 1);
    send(OP_CLASSIFY, 0, 5, 3);
    send(OP_LOAD, 0, 3, 2);
    send(OP_LOAD, 0, 6, 1);
    send(OP_LOAD, 1, 3, 4096);
    send(OP_LOAD, 7, 3, 4096);
    send(OP_LOAD, 2, 4095, CNT_MAX);
    send(OP_MERGE, 0, 0, 0);
    send(OP_MERGE, 0, 0, 0);
    send(OP_MERGE, 0, 0, 0);
    send(OP_MERGE, 0, 0, 0);
    send(OP_CLEAR, 0, 0, 0);
    send(OP_MERGE, 0, 0, 0);
    drain();

    run_round(8, 4, 3);
    setup(4095, 4096, 4096, 8, 7, 65535);
    run_round(6, 3, -1);
    setup(3, 27, 3, 3, 2, 12);
    run_round(12, 6, -1);
    setup(0, 0, 0, 0, 7, 1);
    run_round(4, 3, -1);
    setup(100, 64, 8, 8, 5, 1);
    run_round(10, 4, -1);
    setup(7, 1000, 9, 15, 1, 300);
    run_round(10, 8, 0);
    setup(1, 2, 1, 2, 0, 2);
    run_round(8, 2, -1);

    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
